@@ hw/rtl/bsf4i8d_pkg.sv @@
`timescale 1ns / 1ps

package bsf4i8d_pkg;

    // Activation lanes carried by one request
    localparam int LANES = 4;

    localparam int ACT_W    = 8;
    localparam int NIB_W    = 4;
    localparam int WEIGHT_W = 5;
    localparam int LPROD_W  = ACT_W + WEIGHT_W;
    localparam int DOT_W    = 15;
    localparam int BSUM_W   = 18;
    localparam int BSCALE_W = 16;
    localparam int FPROD_W  = BSUM_W + BSCALE_W + 1;
    localparam int ACC_W    = 48;
    localparam int ASCALE_W = 24;
    localparam int HALF_W   = ACC_W / 2;
    localparam int LOPROD_W = HALF_W + ASCALE_W;
    localparam int HIPROD_W = HALF_W + ASCALE_W + 1;
    localparam int RESULT_W = 64;
    localparam int COUNT_W  = 4;

    // E2M1 magnitudes, doubled so that they are whole numbers
    localparam logic [3:0] FP4_MAG [8] = '{
        4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd6, 4'd8, 4'd12
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DOT,
        ST_FMUL,
        ST_FADD,
        ST_OMUL,
        ST_OUT
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic dot;
        logic fmul;
        logic fadd;
        logic omul;
        logic out_load;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic flush_due;
        logic last;
        logic out_free;
    } status_t;

    // Decode one E2M1 code to a signed doubled value; negative zero gives zero
    function automatic logic signed [WEIGHT_W-1:0] fp4_decode(input logic [NIB_W-1:0] code);
        logic signed [WEIGHT_W-1:0] mag;
        mag = $signed({1'b0, FP4_MAG[code[2:0]]});
        return code[3] ? -mag : mag;
    endfunction

endpackage

@@ hw/rtl/bsf4i8d_ctrl.sv @@
`timescale 1ns / 1ps

module bsf4i8d_ctrl
    import bsf4i8d_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    // Hold the sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Step through dot, group flush and output scaling
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DOT;
                end
            end
            ST_DOT:
            begin
                cmd.dot    = 1'b1;
                state_next = status.flush_due ? ST_FMUL : ST_IDLE;
            end
            ST_FMUL:
            begin
                cmd.fmul   = 1'b1;
                state_next = ST_FADD;
            end
            ST_FADD:
            begin
                cmd.fadd   = 1'b1;
                state_next = status.last ? ST_OMUL : ST_IDLE;
            end
            ST_OMUL:
            begin
                cmd.omul   = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ hw/rtl/bsf4i8d_dp.sv @@
`timescale 1ns / 1ps

module bsf4i8d_dp
    import bsf4i8d_pkg::*;
#(
    parameter int ITEMS_PER_GROUP = 4
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  cmd_t                       cmd,
    output status_t                    status,
    input  logic [LANES*ACT_W-1:0]     act_bytes,
    input  logic [LANES*NIB_W-1:0]     weight_nibbles,
    input  logic [BSCALE_W-1:0]        block_scale,
    input  logic [ASCALE_W-1:0]        row_scale,
    input  logic                       last,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [RESULT_W-1:0] result,
    output logic                       overflow
);

    localparam logic [COUNT_W:0] GroupEnd = (COUNT_W + 1)'(ITEMS_PER_GROUP);

    // Captured request
    logic [LANES*ACT_W-1:0]     act_reg;
    logic [LANES*NIB_W-1:0]     nib_reg;
    logic [BSCALE_W-1:0]        bscale_reg;
    logic [ASCALE_W-1:0]        ascale_reg;
    logic                       last_reg;

    // Running state
    logic [COUNT_W-1:0]         count_reg;
    logic [COUNT_W-1:0]         count_next;
    logic signed [BSUM_W-1:0]   bsum_reg;
    logic signed [BSUM_W-1:0]   bsum_next;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [ACC_W-1:0]    acc_next;
    logic                       sat_reg;
    logic                       sat_next;

    // Product registers
    logic signed [FPROD_W-1:0]  fprod_reg;
    logic [LOPROD_W-1:0]        loprod_reg;
    logic signed [HIPROD_W-1:0] hiprod_reg;

    // Output register
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic signed [RESULT_W-1:0] result_reg;
    logic                       overflow_reg;

    logic signed [LPROD_W-1:0]  lane_prod [LANES];
    logic signed [DOT_W-1:0]    dot_sum;
    logic signed [ACC_W:0]      acc_sum;
    logic signed [HIPROD_W-1:0] scaled;
    logic                       flush_due;

    // Multiply each lane and add the four products
    always_comb
    begin
        dot_sum = '0;
        for (int i = 0; i < LANES; i++)
        begin
            lane_prod[i] = $signed(act_reg[i*ACT_W +: ACT_W])
                         * fp4_decode(nib_reg[i*NIB_W +: NIB_W]);
            dot_sum      = dot_sum + DOT_W'(lane_prod[i]);
        end
    end

    // Group ends on its final item or on the last request
    assign flush_due = (({1'b0, count_reg} + 1'b1) >= GroupEnd) || last_reg;

    // Saturating accumulate of the scaled block sum; cleared when the result is loaded
    always_comb
    begin
        acc_sum  = (ACC_W + 1)'(acc_reg) + (ACC_W + 1)'(fprod_reg);
        acc_next = acc_reg;
        sat_next = sat_reg;
        if (cmd.fadd)
        begin
            if (acc_sum[ACC_W] != acc_sum[ACC_W-1])
            begin
                acc_next = acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}}
                                          : {1'b0, {(ACC_W-1){1'b1}}};
                sat_next = 1'b1;
            end
            else
            begin
                acc_next = acc_sum[ACC_W-1:0];
            end
        end
        else if (cmd.out_load)
        begin
            acc_next = '0;
            sat_next = 1'b0;
        end
    end

    // Advance item count and block sum; clear the block sum when the group is added
    always_comb
    begin
        count_next = count_reg;
        bsum_next  = bsum_reg;
        if (cmd.dot)
        begin
            count_next = flush_due ? '0 : count_reg + 1'b1;
            bsum_next  = bsum_reg + BSUM_W'(dot_sum);
        end
        else if (cmd.fadd)
        begin
            bsum_next = '0;
        end
    end

    // Floor of acc * scale / 2^24 from the high half product and the low half carry
    assign scaled = hiprod_reg + $signed({{(HIPROD_W-ASCALE_W){1'b0}},
                                          loprod_reg[LOPROD_W-1:ASCALE_W]});

    assign out_valid_next = cmd.out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            bsum_reg      <= '0;
            acc_reg       <= '0;
            sat_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            bsum_reg      <= bsum_next;
            acc_reg       <= acc_next;
            sat_reg       <= sat_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg    <= act_bytes;
            nib_reg    <= weight_nibbles;
            bscale_reg <= block_scale;
            ascale_reg <= row_scale;
            last_reg   <= last;
        end
        if (cmd.fmul)
        begin
            fprod_reg <= bsum_reg * $signed({1'b0, bscale_reg});
        end
        if (cmd.omul)
        begin
            loprod_reg <= acc_reg[HALF_W-1:0] * ascale_reg;
            hiprod_reg <= $signed(acc_reg[ACC_W-1:HALF_W]) * $signed({1'b0, ascale_reg});
        end
        if (cmd.out_load)
        begin
            result_reg   <= RESULT_W'(scaled);
            overflow_reg <= sat_reg;
        end
    end

    assign status.flush_due = flush_due;
    assign status.last      = last_reg;
    assign status.out_free  = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign result    = result_reg;
    assign overflow  = overflow_reg;

endmodule

@@ hw/rtl/block_scaled_fp4_int8_dot.sv @@
// Sequence: a request inside a group passes through IDLE and DOT, one that closes a group
// also through FMUL and FADD, and the last request also through OMUL and OUT; the sequencer
// handles one request at a time. The result of the last request is loaded in OUT once the
// output register is free; the accumulator scaling runs as two 24-bit half products.
// Reset: rst_n clears the sequencer, item count, block sum, accumulator and the output
// valid flag at once; the block takes requests as soon as reset is released.
`timescale 1ns / 1ps

module block_scaled_fp4_int8_dot
    import bsf4i8d_pkg::*;
#(
    parameter int GROUP_SIZE = 16
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [LANES*ACT_W-1:0]     act_bytes,
    input  logic [LANES*NIB_W-1:0]     weight_nibbles,
    input  logic [BSCALE_W-1:0]        block_scale,
    input  logic [ASCALE_W-1:0]        row_scale,
    input  logic                       last,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [RESULT_W-1:0] result,
    output logic                       overflow
);

    localparam int ItemsPerGroup = (GROUP_SIZE / LANES == 0) ? 1 : GROUP_SIZE / LANES;

    cmd_t    cmd;
    status_t status;

    bsf4i8d_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    bsf4i8d_dp #(
        .ITEMS_PER_GROUP (ItemsPerGroup)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .act_bytes      (act_bytes),
        .weight_nibbles (weight_nibbles),
        .block_scale    (block_scale),
        .row_scale      (row_scale),
        .last           (last),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .result         (result),
        .overflow       (overflow)
    );

    // One datapath command at a time
    assert property (@(posedge clk) disable iff (!rst_n) $onehot0(cmd))
        else $error("more than one datapath command at once");

    // A result is only produced for the request marked last
    assert property (@(posedge clk) disable iff (!rst_n) cmd.out_load |-> status.last)
        else $error("result loaded for a request not marked last");

    // No new request while one is still being worked on
    assert property (@(posedge clk) disable iff (!rst_n) (in_valid && in_ready) |=> !in_ready)
        else $error("request accepted while the previous one is in progress");

    // A loaded result is offered in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n) cmd.out_load |=> out_valid)
        else $error("loaded result not offered");

endmodule

@@ tb/block_scaled_fp4_int8_dot_test.sv @@
`timescale 1ns / 1ps

module block_scaled_fp4_int8_dot_test;
    import bsf4i8d_pkg::*;

    localparam int GROUP_SIZE      = 16;
    localparam int ITEMS_PER_GROUP = (GROUP_SIZE / LANES) > 0 ? (GROUP_SIZE / LANES) : 1;
    localparam int RANDOM_ITEMS    = 400;
    localparam int QUIET_TAIL      = 80;
    localparam int DRAIN_CYCLES    = 24;
    localparam int STALL_LIMIT     = 2000;
    localparam int REPORT_LIMIT    = 10;

    localparam longint ACC_HI = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint ACC_LO = -ACC_HI - 1;

    // E2M1 magnitudes, twice the real value
    localparam int E2M1_TWICE [8] = '{0, 1, 2, 3, 4, 6, 8, 12};

    typedef struct {
        logic [LANES*ACT_W-1:0] acts;
        logic [LANES*NIB_W-1:0] nibs;
        logic [BSCALE_W-1:0]    bscale;
        logic [ASCALE_W-1:0]    ascale;
        bit                     closes;
        int                     reps;
        bit                     pinned;
        logic signed [63:0]     pin_value;
        bit                     pin_ovf;
    } dot_row_t;

    typedef struct {
        logic signed [RESULT_W-1:0] value;
        bit                         ovf;
    } dot_result_t;

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_ready;
    logic [LANES*ACT_W-1:0]     act_bytes;
    logic [LANES*NIB_W-1:0]     weight_nibbles;
    logic [BSCALE_W-1:0]        block_scale;
    logic [ASCALE_W-1:0]        row_scale;
    logic                       last;
    logic                       out_valid;
    logic                       out_ready;
    logic signed [RESULT_W-1:0] result;
    logic                       overflow;

    // Pinned expectation travelling with the request that closes a dot product
    bit                 pin_on;
    logic signed [63:0] pin_value;
    bit                 pin_ovf;

    // Predictor state
    int     grp_count;
    int     grp_sum;
    longint acc_sum;
    bit     acc_clamped;

    dot_result_t due_results [$];
    dot_row_t    plan [$];

    bit     idle_on;
    int     faults;
    int     requests_taken;
    int     results_seen;
    int     saturated_seen;
    int     quiet_cycles;

    bit                 mon_done;
    logic signed [63:0] mon_value;
    bit                 mon_ovf;
    dot_result_t        mon_entry;

    block_scaled_fp4_int8_dot #(
        .GROUP_SIZE(GROUP_SIZE)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .act_bytes      (act_bytes),
        .weight_nibbles (weight_nibbles),
        .block_scale    (block_scale),
        .row_scale      (row_scale),
        .last           (last),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .result         (result),
        .overflow       (overflow)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Fold one request into the running dot product; flag and return the result on its end
    function automatic void accumulate_request(
        input  logic [LANES*ACT_W-1:0] acts,
        input  logic [LANES*NIB_W-1:0] nibs,
        input  logic [BSCALE_W-1:0]    bscale,
        input  logic [ASCALE_W-1:0]    ascale,
        input  bit                     closes,
        output bit                     done,
        output logic signed [63:0]     value,
        output bit                     ovf
    );
        int                 i;
        int                 a;
        int                 w;
        int                 dot;
        longint             sum;
        logic signed [47:0] acc48;
        logic signed [79:0] prod;
        dot = 0;
        for (i = 0; i < LANES; i++)
        begin
            a = $signed(acts[ACT_W*i +: ACT_W]);
            w = E2M1_TWICE[nibs[NIB_W*i +: 3]];
            // Sign bit on a zero magnitude still gives zero
            if (nibs[NIB_W*i + 3])
                w = -w;
            dot += a * w;
        end
        grp_sum += dot;
        grp_count = (grp_count + 1) & 15;

        // Close the group with the scale carried by this request
        if (grp_count >= ITEMS_PER_GROUP || grp_count == 0 || closes)
        begin
            sum = acc_sum + longint'(grp_sum) * longint'(bscale);
            if (sum > ACC_HI)
            begin
                sum = ACC_HI;
                acc_clamped = 1'b1;
            end
            if (sum < ACC_LO)
            begin
                sum = ACC_LO;
                acc_clamped = 1'b1;
            end
            acc_sum = sum;
            grp_sum = 0;
            grp_count = 0;
        end

        done = closes;
        value = '0;
        ovf = 1'b0;
        if (closes)
        begin
            acc48 = acc_sum[47:0];
            prod = acc48 * $signed({1'b0, ascale});
            value = 64'(prod >>> 24);
            ovf = acc_clamped;
            grp_count = 0;
            grp_sum = 0;
            acc_sum = 0;
            acc_clamped = 1'b0;
        end
    endfunction

    task automatic report_fault(input string msg);
        faults++;
        if (faults <= REPORT_LIMIT)
            $display("%0t: %s", $time, msg);
    endtask

    // Present one request and hold it until the block takes it
    task automatic send_request(
        input logic [LANES*ACT_W-1:0] acts,
        input logic [LANES*NIB_W-1:0] nibs,
        input logic [BSCALE_W-1:0]    bscale,
        input logic [ASCALE_W-1:0]    ascale,
        input bit                     closes,
        input bit                     pin,
        input logic signed [63:0]     pval,
        input bit                     povf
    );
        int gap;
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 13);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        act_bytes      <= acts;
        weight_nibbles <= nibs;
        block_scale    <= bscale;
        row_scale      <= ascale;
        last           <= closes;
        pin_on         <= pin;
        pin_value      <= pval;
        pin_ovf        <= povf;
        in_valid       <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Stall the result side in random bursts
    always
    begin
        @(negedge clk);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            out_ready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clk);
            out_ready <= 1'b1;
        end
    end

    // Check results, predict accepted requests and watch for a hang
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (overflow)
                    saturated_seen++;
                if (due_results.size() == 0)
                    report_fault($sformatf("unexpected result %0d overflow %0b",
                                           result, overflow));
                else
                begin
                    mon_entry = due_results.pop_front();
                    if (result !== mon_entry.value)
                        report_fault($sformatf("result: expected %0d, got %0d",
                                               mon_entry.value, result));
                    if (overflow !== mon_entry.ovf)
                        report_fault($sformatf("overflow: expected %0b, got %0b",
                                               mon_entry.ovf, overflow));
                end
            end

            if (in_valid && in_ready)
            begin
                requests_taken++;
                accumulate_request(act_bytes, weight_nibbles, block_scale, row_scale, last,
                                   mon_done, mon_value, mon_ovf);
                if (mon_done)
                begin
                    mon_entry.value = pin_on ? pin_value : mon_value;
                    mon_entry.ovf   = pin_on ? pin_ovf : mon_ovf;
                    due_results.push_back(mon_entry);
                end
            end

            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles == STALL_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial
    begin
        int                     r;
        int                     n;
        int                     b;
        int                     len;
        int                     sent;
        int                     dots;
        bit                     closes;
        bit                     pressed;
        logic [LANES*ACT_W-1:0] acts;
        logic [LANES*NIB_W-1:0] nibs;
        logic [BSCALE_W-1:0]    bscale;
        logic [ASCALE_W-1:0]    ascale;

        rst_n          = 1'b0;
        in_valid       = 1'b0;
        act_bytes      = '0;
        weight_nibbles = '0;
        block_scale    = '0;
        row_scale      = '0;
        last           = 1'b0;
        out_ready      = 1'b1;
        pin_on         = 1'b0;
        pin_value      = '0;
        pin_ovf        = 1'b0;
        idle_on        = 1'b1;
        faults         = 0;
        requests_taken = 0;
        results_seen   = 0;
        saturated_seen = 0;
        quiet_cycles   = 0;
        grp_count      = 0;
        grp_sum        = 0;
        acc_sum        = 0;
        acc_clamped    = 1'b0;
        pressed        = 1'b0;
        dots           = 0;

        // Directed plan: acts, nibbles, block scale, act scale, last, repeats, pinned result
        plan.push_back('{32'h0000_0000, 16'h0000, 16'h0000, 24'h000000, 1, 1, 1, 0, 0});
        plan.push_back('{32'h7F7F_7F7F, 16'h7777, 16'hFFFF, 24'hFFFFFF, 1, 1, 0, 0, 0});
        plan.push_back('{32'h8080_8080, 16'h7777, 16'hFFFF, 24'hFFFFFF, 1, 1, 0, 0, 0});
        plan.push_back('{32'h8080_8080, 16'hFFFF, 16'h8000, 24'h800000, 1, 1, 0, 0, 0});
        // Negative zero weights cancel any activation
        plan.push_back('{32'h807F_01FF, 16'h8888, 16'hFFFF, 24'hFFFFFF, 1, 1, 1, 0, 0});
        // Every weight code; the group takes the scale of its closing request
        plan.push_back('{32'h0101_0101, 16'h3210, 16'h1234, 24'h000000, 0, 1, 0, 0, 0});
        plan.push_back('{32'h0101_0101, 16'h7654, 16'h2345, 24'h000000, 0, 1, 0, 0, 0});
        plan.push_back('{32'h0101_0101, 16'hBA98, 16'h3456, 24'h000000, 0, 1, 0, 0, 0});
        plan.push_back('{32'h0101_0101, 16'hFEDC, 16'h4567, 24'h000000, 0, 1, 0, 0, 0});
        plan.push_back('{32'hFF01_FF01, 16'h1357, 16'hABCD, 24'h9ABCDE, 1, 1, 0, 0, 0});
        // Zero scales wipe the dot product
        plan.push_back('{32'h7F7F_7F7F, 16'h7777, 16'hFFFF, 24'h000000, 1, 1, 1, 0, 0});
        plan.push_back('{32'h1234_5678, 16'h5A5A, 16'h0000, 24'hFFFFFF, 1, 3, 1, 0, 0});
        // Last on a group boundary, then last part way into a group
        plan.push_back('{32'h9C64_F00E, 16'hE3C1, 16'h7001, 24'h123456, 1, 4, 0, 0, 0});
        plan.push_back('{32'h7F80_7F80, 16'h79F7, 16'hC350, 24'hF00000, 1, 7, 0, 0, 0});
        // Floor of the final shift on tiny positive and negative values
        plan.push_back('{32'h0101_0101, 16'h1111, 16'h0001, 24'h000001, 1, 1, 0, 0, 0});
        plan.push_back('{32'hFFFF_FFFF, 16'h1111, 16'h0001, 24'h000001, 1, 1, 0, 0, 0});
        // Zero activations with a full scale give zero
        plan.push_back('{32'h0000_0000, 16'h0000, 16'h0000, 24'hFFFFFF, 1, 1, 1, 0, 0});

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Walk the directed plan
        for (r = 0; r < plan.size(); r++)
        begin
            idle_on = (plan[r].reps < 100);
            for (n = 0; n < plan[r].reps; n++)
            begin
                closes = plan[r].closes && (n == plan[r].reps - 1);
                send_request(plan[r].acts, plan[r].nibs, plan[r].bscale, plan[r].ascale,
                             closes, closes && plan[r].pinned, plan[r].pin_value,
                             plan[r].pin_ovf);
            end
            if (plan[r].closes)
                dots++;
        end

        // Random dot products of mixed length with weighted extremes
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if (!pressed && sent >= RANDOM_ITEMS / 2)
            begin
                // Hold off until the block has delivered everything
                in_valid <= 1'b0;
                @(negedge clk);
                while (due_results.size() != 0)
                    @(negedge clk);
                pressed = 1'b1;
            end
            idle_on = (sent < RANDOM_ITEMS - QUIET_TAIL);
            len = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 24) : $urandom_range(1, 9);
            for (n = 0; n < len; n++)
            begin
                for (b = 0; b < LANES; b++)
                begin
                    case ($urandom_range(0, 7))
                        0:       acts[ACT_W*b +: ACT_W] = 8'h80;
                        1:       acts[ACT_W*b +: ACT_W] = 8'h7F;
                        default: acts[ACT_W*b +: ACT_W] = $urandom;
                    endcase
                end
                nibs = $urandom;
                case ($urandom_range(0, 7))
                    0:       bscale = '0;
                    1:       bscale = '1;
                    default: bscale = $urandom;
                endcase
                case ($urandom_range(0, 7))
                    0:       ascale = '0;
                    1:       ascale = '1;
                    default: ascale = $urandom;
                endcase
                send_request(acts, nibs, bscale, ascale, n == len - 1, 1'b0, '0, 1'b0);
            end
            sent += len;
            dots++;
        end

        // Drain outstanding results
        in_valid <= 1'b0;
        idle_on = 1'b0;
        @(negedge clk);
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d requests over %0d dot products, %0d results, %0d saturated.",
                 requests_taken, dots, results_seen, saturated_seen);
        $display("Included every weight code, negative zero, zero scales and floor rounding.");
        if (faults == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/bsf4i8d_pkg.sv
hw/rtl/bsf4i8d_ctrl.sv
hw/rtl/bsf4i8d_dp.sv
hw/rtl/block_scaled_fp4_int8_dot.sv
tb/block_scaled_fp4_int8_dot_test.sv
